[rtl/core/ssc_pkg.sv]
package ssc_pkg;

	// Default build
	localparam int STEP_COUNT_DEF  = 32;
	localparam int LEVEL_WIDTH_DEF = 16;

	// Fixed field widths
	localparam int STEP_W     = 5;
	localparam int LEVEL_IN_W = 16;
	localparam int CV_W       = 15;
	localparam int FUNC_W     = 3;
	localparam int INDEX_W    = 6;
	localparam int MODE_W     = 2;
	localparam int RUN_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int LFSR_W     = 16;

	localparam int GATE_A_BIT = 13;
	localparam int GATE_B_BIT = 14;

	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
	localparam logic [STEP_W-1:0] FINISH_RESET = 5'd15;

	// Item function codes
	localparam logic [FUNC_W-1:0] FUNC_PIN   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_JOG   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_TRIG  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_LEVEL = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_RUN   = 3'd4;

	// Play modes
	localparam logic [MODE_W-1:0] MODE_NORMAL   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PENDULUM = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RANDOM   = 2'd2;

	// Run commands
	localparam logic [RUN_W-1:0] RUN_STOP  = 2'd0;
	localparam logic [RUN_W-1:0] RUN_START = 2'd1;
	localparam logic [RUN_W-1:0] RUN_RESET = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FINISH    = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MOD,
		ST_READ,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic              start;
		logic [LFSR_W-1:0] dividend;
		logic [STEP_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic              done;
		logic [STEP_W-1:0] rem;
	} mod_rsp_t;

endpackage

[rtl/core/step_sequencer_channel.sv]
// One channel of a step sequencer. Each input word is one event: a sample of
// the clock and reset pins, a jog, a manual trigger, a level-table write or
// a run/stop/reset command. Every input word yields exactly one output word
// with the step, run flag, CV load strobes, CV value and trigger levels.
// The config channel writes play mode, start step and finish step; it is
// taken only while no word is in work.
// Sequence: an input word is worked on alone. Jog, table writes, run control,
// pin samples that only drop the triggers and other words that do not read
// the level table raise out_valid from ST_EXEC; a normal or pendulum step,
// and a manual trigger press, go on through ST_READ and ST_LOAD.
// A random step with start and finish apart runs the 16-bit LFSR value
// through a remainder unit (ST_MOD) that retires one dividend bit per cycle.
// A new word is taken the cycle after the previous result has been taken.
// A stalled receiver holds the result and blocks further input words.
// Reset: all step, trigger and run state cleared, finish step 15, LFSR
// seeded, level table reads as zero at once (per-entry valid bits).
module step_sequencer_channel #(
	parameter int STEP_COUNT  = ssc_pkg::STEP_COUNT_DEF,
	parameter int LEVEL_WIDTH = ssc_pkg::LEVEL_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ssc_pkg::FUNC_W-1:0]        func,
	input  logic                              clock_pin,
	input  logic                              reset_pin,
	input  logic                              jog_reverse,
	input  logic                              trigger_up,
	input  logic [ssc_pkg::INDEX_W-1:0]       level_index,
	input  logic [ssc_pkg::LEVEL_IN_W-1:0]    level_value,
	input  logic [ssc_pkg::RUN_W-1:0]         run_command,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ssc_pkg::STEP_W-1:0]        current_step,
	output logic                              is_running,
	output logic                              cv_a_load,
	output logic                              cv_b_load,
	output logic [ssc_pkg::CV_W-1:0]          cv_value,
	output logic                              gate_a,
	output logic                              gate_b,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ssc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssc_pkg::STEP_W-1:0]        cfg_data
);

	localparam int AddrW = $clog2(STEP_COUNT);
	localparam int LimW  = $clog2(STEP_COUNT + 1);
	localparam int ExtW  = (LimW > ssc_pkg::INDEX_W) ? LimW : ssc_pkg::INDEX_W;
	localparam logic [ExtW-1:0] StepLim = ExtW'(STEP_COUNT);

	ssc_pkg::state_t state_q, state_d;

	logic out_valid_q, out_valid_d;
	logic [ssc_pkg::STEP_W-1:0] step_q, step_d;
	logic flip_q, flip_d;
	logic last_clk_q, last_clk_d;
	logic running_q, running_d;
	logic gate_a_q, gate_a_d;
	logic gate_b_q, gate_b_d;
	logic [ssc_pkg::LFSR_W-1:0] lfsr_q, lfsr_d;
	logic la_q, la_d;
	logic lb_q, lb_d;
	logic [ssc_pkg::CV_W-1:0] cv_q, cv_d;

	logic [ssc_pkg::MODE_W-1:0] mode_q;
	logic [ssc_pkg::STEP_W-1:0] start_q;
	logic [ssc_pkg::STEP_W-1:0] finish_q;

	logic [ssc_pkg::FUNC_W-1:0]     func_q;
	logic                           clock_pin_q;
	logic                           reset_pin_q;
	logic                           jog_reverse_q;
	logic                           trigger_up_q;
	logic [ssc_pkg::INDEX_W-1:0]    level_index_q;
	logic [ssc_pkg::LEVEL_IN_W-1:0] level_value_q;
	logic [ssc_pkg::RUN_W-1:0]      run_command_q;

	ssc_pkg::mod_req_t mod_req;
	ssc_pkg::mod_rsp_t mod_rsp;

	logic                   wr_en;
	logic                   rd_en;
	logic [AddrW-1:0]       wr_addr;
	logic [AddrW-1:0]       rd_addr;
	logic [LEVEL_WIDTH-1:0] rd_data;

	logic [ssc_pkg::STEP_W-1:0]     lo, hi, base_step, nrm_step, jog_next;
	logic                           asc, rst_req, base_flip, fwd, clk_lvl, in_acc;
	logic [ssc_pkg::LFSR_W-1:0]     lfsr_next;
	logic [ExtW-1:0]                step_ext, idx_ext;
	logic [ssc_pkg::LEVEL_IN_W-1:0] lvl;

	assign in_ready  = (state_q == ssc_pkg::ST_IDLE) && !out_valid_q;
	assign cfg_ready = (state_q == ssc_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;

	assign asc = (start_q < finish_q);
	assign lo  = asc ? start_q : finish_q;
	assign hi  = asc ? finish_q : start_q;

	// a low reset pin lands on finish before any clock edge is handled
	assign rst_req   = (func_q == ssc_pkg::FUNC_PIN) && !reset_pin_q;
	assign base_step = rst_req ? finish_q : step_q;
	assign base_flip = rst_req ? 1'b0 : flip_q;
	assign fwd       = base_flip ^ asc;
	assign clk_lvl   = ~clock_pin_q;

	always_comb begin
		if (fwd) begin
			nrm_step = (base_step < hi) ? base_step + 1'b1 : lo;
		end else begin
			nrm_step = (base_step > lo) ? base_step - 1'b1 : hi;
		end
	end

	always_comb begin
		if (jog_reverse_q) begin
			if (finish_q > start_q) begin
				jog_next = (step_q > start_q) ? step_q - 1'b1 : finish_q;
			end else begin
				jog_next = (step_q < start_q) ? step_q + 1'b1 : finish_q;
			end
		end else begin
			if (finish_q > start_q) begin
				jog_next = (step_q < finish_q) ? step_q + 1'b1 : start_q;
			end else begin
				jog_next = (step_q > finish_q) ? step_q - 1'b1 : start_q;
			end
		end
	end

	assign lfsr_next = {1'b0, lfsr_q[ssc_pkg::LFSR_W-1:1]}
	                 ^ (lfsr_q[0] ? ssc_pkg::LFSR_TAPS : '0);

	assign step_ext = ExtW'(step_q);
	assign idx_ext  = ExtW'(level_index_q);
	assign rd_addr  = step_ext[AddrW-1:0];
	assign wr_addr  = idx_ext[AddrW-1:0];
	assign lvl      = (step_ext < StepLim) ? ssc_pkg::LEVEL_IN_W'(rd_data) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q;
		step_d      = step_q;
		flip_d      = flip_q;
		last_clk_d  = last_clk_q;
		running_d   = running_q;
		gate_a_d    = gate_a_q;
		gate_b_d    = gate_b_q;
		lfsr_d      = lfsr_q;
		la_d        = la_q;
		lb_d        = lb_q;
		cv_d        = cv_q;
		mod_req     = '0;
		rd_en       = 1'b0;
		wr_en       = 1'b0;

		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			ssc_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = ssc_pkg::ST_EXEC;
					la_d    = 1'b0;
					lb_d    = 1'b0;
					cv_d    = '0;
				end
			end
			ssc_pkg::ST_EXEC: begin
				state_d = ssc_pkg::ST_IDLE;
				case (func_q)
					ssc_pkg::FUNC_PIN: begin
						step_d = base_step;
						flip_d = base_flip;
						if (clk_lvl != last_clk_q) begin
							last_clk_d = clk_lvl;
							if (clk_lvl && running_q) begin
								if (mode_q == ssc_pkg::MODE_RANDOM) begin
									lfsr_d = lfsr_next;
									if (hi > lo) begin
										mod_req.start    = 1'b1;
										mod_req.dividend = lfsr_next;
										mod_req.divisor  = hi - lo;
										state_d          = ssc_pkg::ST_MOD;
									end else begin
										step_d  = lo;
										state_d = ssc_pkg::ST_READ;
									end
								end else begin
									step_d = nrm_step;
									if (mode_q == ssc_pkg::MODE_PENDULUM &&
									    (nrm_step == hi || nrm_step == lo)) begin
										flip_d = ~base_flip;
									end
									state_d = ssc_pkg::ST_READ;
								end
							end else begin
								gate_a_d = 1'b0;
								gate_b_d = 1'b0;
							end
						end
					end
					ssc_pkg::FUNC_JOG: begin
						step_d = jog_next;
					end
					ssc_pkg::FUNC_TRIG: begin
						if (!running_q) begin
							if (trigger_up_q) begin
								state_d = ssc_pkg::ST_READ;
							end else begin
								gate_a_d = 1'b0;
								gate_b_d = 1'b0;
							end
						end
					end
					ssc_pkg::FUNC_LEVEL: begin
						wr_en = (idx_ext < StepLim);
					end
					ssc_pkg::FUNC_RUN: begin
						case (run_command_q)
							ssc_pkg::RUN_STOP:  running_d = 1'b0;
							ssc_pkg::RUN_START: running_d = 1'b1;
							ssc_pkg::RUN_RESET: begin
								step_d = finish_q;
								flip_d = 1'b0;
							end
							default: ;
						endcase
					end
					default: ;
				endcase
				if (state_d == ssc_pkg::ST_IDLE) begin
					out_valid_d = 1'b1;
				end
			end
			ssc_pkg::ST_MOD: begin
				if (mod_rsp.done) begin
					step_d  = lo + mod_rsp.rem;
					state_d = ssc_pkg::ST_READ;
				end
			end
			ssc_pkg::ST_READ: begin
				rd_en   = 1'b1;
				state_d = ssc_pkg::ST_LOAD;
			end
			ssc_pkg::ST_LOAD: begin
				if (lvl[ssc_pkg::GATE_A_BIT]) begin
					la_d     = 1'b1;
					cv_d     = lvl[ssc_pkg::LEVEL_IN_W-1:1];
					gate_a_d = 1'b1;
				end
				if (lvl[ssc_pkg::GATE_B_BIT]) begin
					lb_d     = 1'b1;
					cv_d     = lvl[ssc_pkg::LEVEL_IN_W-1:1];
					gate_b_d = 1'b1;
				end
				out_valid_d = 1'b1;
				state_d     = ssc_pkg::ST_IDLE;
			end
			default: begin
				state_d = ssc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
			flip_q      <= 1'b0;
			last_clk_q  <= 1'b0;
			running_q   <= 1'b0;
			gate_a_q    <= 1'b0;
			gate_b_q    <= 1'b0;
			lfsr_q      <= ssc_pkg::LFSR_SEED;
			la_q        <= 1'b0;
			lb_q        <= 1'b0;
			cv_q        <= '0;
		end else begin
			out_valid_q <= out_valid_d;
			step_q      <= step_d;
			flip_q      <= flip_d;
			last_clk_q  <= last_clk_d;
			running_q   <= running_d;
			gate_a_q    <= gate_a_d;
			gate_b_q    <= gate_b_d;
			lfsr_q      <= lfsr_d;
			la_q        <= la_d;
			lb_q        <= lb_d;
			cv_q        <= cv_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ssc_pkg::MODE_NORMAL;
			start_q  <= '0;
			finish_q <= ssc_pkg::FINISH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ssc_pkg::CFG_PLAY_MODE: mode_q   <= cfg_data[ssc_pkg::MODE_W-1:0];
				ssc_pkg::CFG_START:     start_q  <= cfg_data;
				ssc_pkg::CFG_FINISH:    finish_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q        <= func;
			clock_pin_q   <= clock_pin;
			reset_pin_q   <= reset_pin;
			jog_reverse_q <= jog_reverse;
			trigger_up_q  <= trigger_up;
			level_index_q <= level_index;
			level_value_q <= level_value;
			run_command_q <= run_command;
		end
	end

	ssc_rem_unit u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	ssc_level_mem #(
		.DEPTH  (STEP_COUNT),
		.DATA_W (LEVEL_WIDTH)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (level_value_q[LEVEL_WIDTH-1:0]),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_valid    = out_valid_q;
	assign current_step = step_q;
	assign is_running   = running_q;
	assign cv_a_load    = la_q;
	assign cv_b_load    = lb_q;
	assign cv_value     = cv_q;
	assign gate_a       = gate_a_q;
	assign gate_b       = gate_b_q;

	a_rem_done_in_mod: assert property (@(posedge clk) disable iff (!arst_n)
		mod_rsp.done |-> (state_q == ssc_pkg::ST_MOD))
		else $error("remainder finished outside its wait state");

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ssc_pkg::ST_IDLE) |-> !out_valid_q)
		else $error("result pending while a word is in work");

	a_load_sets_gate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((!la_q || gate_a_q) && (!lb_q || gate_b_q)))
		else $error("cv load without its trigger raised");

	a_cv_zero_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !la_q && !lb_q) |-> (cv_q == '0))
		else $error("cv value nonzero without a load");

endmodule

[rtl/core/ssc_rem_unit.sv]
module ssc_rem_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  ssc_pkg::mod_req_t req,
	output ssc_pkg::mod_rsp_t rsp
);

	localparam int CntW = $clog2(ssc_pkg::LFSR_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CntW-1:0]             cnt_q;
	logic [ssc_pkg::LFSR_W-1:0]  dvd_q;
	logic [ssc_pkg::STEP_W-1:0]  div_q;
	logic [ssc_pkg::STEP_W-1:0]  rem_q;
	logic [ssc_pkg::STEP_W:0]    trial;
	logic                        fits;

	// restoring remainder, one dividend bit per cycle
	assign trial = {rem_q, dvd_q[ssc_pkg::LFSR_W-1]};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ssc_pkg::LFSR_W-2:0], 1'b0};
			rem_q <= fits ? ssc_pkg::STEP_W'(trial - {1'b0, div_q})
			              : trial[ssc_pkg::STEP_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < div_q))
		else $error("partial remainder not below divisor");

endmodule

[rtl/core/ssc_level_mem.sv]
module ssc_level_mem #(
	parameter int DEPTH  = ssc_pkg::STEP_COUNT_DEF,
	parameter int DATA_W = ssc_pkg::LEVEL_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] rd_q;
	logic              rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

[test/step_sequencer_channel_checker.sv]
module step_sequencer_channel_checker import ssc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [FUNC_W-1:0]     func,
	input  logic                  clock_pin,
	input  logic                  reset_pin,
	input  logic                  jog_reverse,
	input  logic                  trigger_up,
	input  logic [INDEX_W-1:0]    level_index,
	input  logic [LEVEL_IN_W-1:0] level_value,
	input  logic [RUN_W-1:0]      run_command,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [STEP_W-1:0]     current_step,
	input  logic                  is_running,
	input  logic                  cv_a_load,
	input  logic                  cv_b_load,
	input  logic [CV_W-1:0]       cv_value,
	input  logic                  gate_a,
	input  logic                  gate_b,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [STEP_W-1:0]     cfg_data,
	output int                    fail_count,
	output int                    pending_words
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic              running;
		logic              load_a;
		logic              load_b;
		logic [CV_W-1:0]   cv;
		logic              gate_a;
		logic              gate_b;
	} step_word_t;

	step_word_t step_words_due[$];

	// channel settings
	logic [MODE_W-1:0] mode_r;
	logic [STEP_W-1:0] first_r;
	logic [STEP_W-1:0] last_r;

	// channel state
	logic [STEP_W-1:0]     step_r;
	logic                  swing_r;
	logic                  clock_r;
	logic                  run_r;
	logic                  gate_a_r;
	logic                  gate_b_r;
	logic [LEVEL_IN_W-1:0] levels [STEP_COUNT_DEF];
	logic [LFSR_W-1:0]     lfsr_r;

	task automatic report_mismatch(input string msg);
		if (fail_count < 64)
			$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic park_on_finish();
		step_r = last_r;
		swing_r = 1'b0;
	endtask

	task automatic advance_step();
		logic [STEP_W-1:0] lo;
		logic [STEP_W-1:0] hi;
		logic              fwd;
		logic              lsb;
		int                span;
		lo = (first_r < last_r) ? first_r : last_r;
		hi = (first_r < last_r) ? last_r : first_r;
		fwd = swing_r ^ (first_r < last_r);
		if (mode_r == MODE_RANDOM) begin
			lsb = lfsr_r[0];
			lfsr_r = lfsr_r >> 1;
			if (lsb)
				lfsr_r = lfsr_r ^ LFSR_TAPS;
			// hi itself is never drawn
			span = int'(hi) - int'(lo);
			step_r = (span > 0) ? STEP_W'(int'(lo) + int'(lfsr_r) % span) : lo;
		end else if (fwd) begin
			step_r = (step_r < hi) ? step_r + 1'b1 : lo;
		end else begin
			step_r = (step_r > lo) ? step_r - 1'b1 : hi;
		end
		if (mode_r == MODE_PENDULUM && (step_r == hi || step_r == lo))
			swing_r = ~swing_r;
	endtask

	task automatic jog_step();
		if (jog_reverse) begin
			if (last_r > first_r)
				step_r = (step_r > first_r) ? step_r - 1'b1 : last_r;
			else
				step_r = (step_r < first_r) ? step_r + 1'b1 : last_r;
		end else begin
			if (last_r > first_r)
				step_r = (step_r < last_r) ? step_r + 1'b1 : first_r;
			else
				step_r = (step_r > last_r) ? step_r - 1'b1 : first_r;
		end
	endtask

	// gate bits of the current level fire the CV loads and raise the triggers
	task automatic load_levels(inout step_word_t w);
		logic [LEVEL_IN_W-1:0] x;
		x = levels[step_r];
		if (x[GATE_A_BIT]) begin
			w.load_a = 1'b1;
			w.cv = x[LEVEL_IN_W-1:1];
			gate_a_r = 1'b1;
		end
		if (x[GATE_B_BIT]) begin
			w.load_b = 1'b1;
			w.cv = x[LEVEL_IN_W-1:1];
			gate_b_r = 1'b1;
		end
	endtask

	task automatic predict_word(output step_word_t w);
		logic clk_level;
		w = '0;
		case (func)
			FUNC_PIN: begin
				clk_level = ~clock_pin;
				if (!reset_pin)
					park_on_finish();
				if (clk_level != clock_r) begin
					if (clk_level && run_r) begin
						advance_step();
						load_levels(w);
					end else begin
						gate_a_r = 1'b0;
						gate_b_r = 1'b0;
					end
					clock_r = clk_level;
				end
			end
			FUNC_JOG: jog_step();
			FUNC_TRIG: begin
				if (!run_r) begin
					if (trigger_up) begin
						load_levels(w);
					end else begin
						gate_a_r = 1'b0;
						gate_b_r = 1'b0;
					end
				end
			end
			FUNC_LEVEL: begin
				if (level_index < INDEX_W'(STEP_COUNT_DEF))
					levels[level_index[STEP_W-1:0]] = level_value;
			end
			FUNC_RUN: begin
				case (run_command)
					RUN_STOP: run_r = 1'b0;
					RUN_START: run_r = 1'b1;
					RUN_RESET: park_on_finish();
					default: ;
				endcase
			end
			default: ;
		endcase
		w.step = step_r;
		w.running = run_r;
		w.gate_a = gate_a_r;
		w.gate_b = gate_b_r;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		step_word_t got;
		step_word_t want;
		if (!arst_n) begin
			mode_r = MODE_NORMAL;
			first_r = '0;
			last_r = FINISH_RESET;
			step_r = '0;
			swing_r = 1'b0;
			clock_r = 1'b0;
			run_r = 1'b0;
			gate_a_r = 1'b0;
			gate_b_r = 1'b0;
			for (int i = 0; i < STEP_COUNT_DEF; i++)
				levels[i] = '0;
			lfsr_r = LFSR_SEED;
			step_words_due.delete();
			fail_count = 0;
			pending_words = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PLAY_MODE: mode_r = cfg_data[MODE_W-1:0];
					CFG_START: first_r = cfg_data;
					CFG_FINISH: last_r = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = '{current_step, is_running, cv_a_load, cv_b_load, cv_value,
					gate_a, gate_b};
				if (step_words_due.size() == 0) begin
					report_mismatch($sformatf("output word with none pending: %h", got));
				end else begin
					want = step_words_due.pop_front();
					if (got.step !== want.step)
						report_mismatch($sformatf("current_step %0d, expected %0d",
							got.step, want.step));
					if (got.running !== want.running)
						report_mismatch($sformatf("is_running %b, expected %b",
							got.running, want.running));
					if (got.load_a !== want.load_a)
						report_mismatch($sformatf("cv_a_load %b, expected %b",
							got.load_a, want.load_a));
					if (got.load_b !== want.load_b)
						report_mismatch($sformatf("cv_b_load %b, expected %b",
							got.load_b, want.load_b));
					if (got.cv !== want.cv)
						report_mismatch($sformatf("cv_value %h, expected %h",
							got.cv, want.cv));
					if (got.gate_a !== want.gate_a)
						report_mismatch($sformatf("gate_a %b, expected %b",
							got.gate_a, want.gate_a));
					if (got.gate_b !== want.gate_b)
						report_mismatch($sformatf("gate_b %b, expected %b",
							got.gate_b, want.gate_b));
				end
			end
			if (in_valid && in_ready) begin
				predict_word(want);
				step_words_due.push_back(want);
			end
			pending_words = step_words_due.size();
		end
	end

endmodule

[test/step_sequencer_channel_test.sv]
module step_sequencer_channel_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ssc_pkg::*;

	localparam logic [FUNC_W-1:0]    FUNC_UNUSED_FIRST = 3'd5;
	localparam logic [FUNC_W-1:0]    FUNC_UNUSED_LAST  = 3'd7;
	localparam logic [RUN_W-1:0]     RUN_UNUSED        = 2'd3;
	localparam logic [MODE_W-1:0]    MODE_UNUSED       = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED        = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [FUNC_W-1:0]     func = FUNC_PIN;
	logic                  clock_pin = 1'b1;
	logic                  reset_pin = 1'b1;
	logic                  jog_reverse = 1'b0;
	logic                  trigger_up = 1'b0;
	logic [INDEX_W-1:0]    level_index = '0;
	logic [LEVEL_IN_W-1:0] level_value = '0;
	logic [RUN_W-1:0]      run_command = RUN_STOP;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [STEP_W-1:0]     current_step;
	logic                  is_running;
	logic                  cv_a_load;
	logic                  cv_b_load;
	logic [CV_W-1:0]       cv_value;
	logic                  gate_a;
	logic                  gate_b;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_PLAY_MODE;
	logic [STEP_W-1:0]     cfg_data = '0;

	int fail_count;
	int pending_words;
	int send_idle_pct = 18;
	int recv_idle_pct = 56;
	// last clock pin level sent, so most pin samples make an edge
	logic pin_level = 1'b1;

	step_sequencer_channel u_dut (.*);

	step_sequencer_channel_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// leaves in_valid high on return; the next call or the caller drops it
	task automatic send_word(input logic [FUNC_W-1:0] f, input logic cp, input logic rp,
			input logic jr, input logic tu, input logic [INDEX_W-1:0] idx,
			input logic [LEVEL_IN_W-1:0] val, input logic [RUN_W-1:0] rc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		clock_pin <= cp;
		reset_pin <= rp;
		jog_reverse <= jr;
		trigger_up <= tu;
		level_index <= idx;
		level_value <= val;
		run_command <= rc;
		if (f == FUNC_PIN)
			pin_level = cp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random_word();
		logic [FUNC_W-1:0]  f;
		logic               cp;
		logic               rp;
		logic [INDEX_W-1:0] idx;
		logic [RUN_W-1:0]   rc;
		int                 pick;
		int                 roll;
		pick = $urandom_range(99);
		roll = $urandom_range(9);
		cp = 1'($urandom_range(1));
		rp = ($urandom_range(19) != 0);
		idx = (roll == 0) ? INDEX_W'($urandom_range(63, 32)) : INDEX_W'($urandom_range(31));
		rc = (roll < 5) ? RUN_START : (roll < 7) ? RUN_STOP : (roll < 9) ? RUN_RESET
			: RUN_UNUSED;
		if (pick < 60) begin
			f = FUNC_PIN;
			cp = (pick < 52) ? ~pin_level : pin_level;
		end else if (pick < 67) begin
			f = FUNC_JOG;
		end else if (pick < 74) begin
			f = FUNC_TRIG;
		end else if (pick < 84) begin
			f = FUNC_LEVEL;
		end else if (pick < 94) begin
			f = FUNC_RUN;
		end else begin
			f = FUNC_W'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
		end
		send_word(f, cp, rp, 1'($urandom_range(1)), 1'($urandom_range(1)), idx,
			16'($urandom), rc);
	endtask

	// block must be drained before the settings change
	task automatic apply_settings(input logic [MODE_W-1:0] mode_w,
			input logic [STEP_W-1:0] first, input logic [STEP_W-1:0] last, input bit spare);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [STEP_W-1:0]    data [4];
		idx = '{CFG_PLAY_MODE, CFG_START, CFG_FINISH, CFG_UNUSED};
		data = '{{3'($urandom_range(7)), mode_w}, first, last, 5'($urandom_range(31))};
		in_valid <= 1'b0;
		while (pending_words != 0)
			@(negedge clk);
		for (int n = 0; n < (spare ? 4 : 3); n++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[n];
			cfg_data <= data[n];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [MODE_W-1:0] mode_w;
		logic [STEP_W-1:0] first;
		logic [STEP_W-1:0] last;
		repeat (5)
			@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: normal order over steps 0..15
		send_word(FUNC_LEVEL, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 16'hFFFF, RUN_STOP);
		send_word(FUNC_LEVEL, 1'b1, 1'b1, 1'b0, 1'b0, 6'd1, 16'h2000, RUN_STOP);
		send_word(FUNC_LEVEL, 1'b1, 1'b1, 1'b0, 1'b0, 6'd2, 16'h4000, RUN_STOP);
		send_word(FUNC_LEVEL, 1'b1, 1'b1, 1'b0, 1'b0, 6'd31, 16'h6001, RUN_STOP);
		// indexes past the table are dropped
		send_word(FUNC_LEVEL, 1'b1, 1'b1, 1'b0, 1'b0, 6'd32, 16'hFFFF, RUN_STOP);
		send_word(FUNC_LEVEL, 1'b1, 1'b1, 1'b0, 1'b0, 6'd63, 16'h5555, RUN_STOP);
		send_word(FUNC_TRIG, 1'b1, 1'b1, 1'b0, 1'b1, 6'd0, 16'h0000, RUN_STOP);
		send_word(FUNC_TRIG, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_STOP);
		send_word(FUNC_JOG, 1'b1, 1'b1, 1'b1, 1'b0, 6'd0, 16'h0000, RUN_STOP);
		send_word(FUNC_JOG, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_STOP);
		// clock edges while stopped only drop the triggers
		send_word(FUNC_PIN, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_STOP);
		send_word(FUNC_PIN, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_STOP);
		send_word(FUNC_RUN, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_START);
		send_word(FUNC_PIN, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_STOP);
		// manual trigger is ignored while running
		send_word(FUNC_TRIG, 1'b0, 1'b1, 1'b0, 1'b1, 6'd0, 16'h0000, RUN_STOP);
		send_word(FUNC_PIN, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_STOP);
		send_word(FUNC_PIN, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_STOP);
		send_word(FUNC_PIN, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_STOP);
		send_word(FUNC_PIN, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_STOP);
		// step sits on the upper end, so the next edge wraps to the start
		send_word(FUNC_PIN, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_STOP);
		send_word(FUNC_RUN, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_UNUSED);
		send_word(FUNC_UNUSED_FIRST, 1'b0, 1'b1, 1'b1, 1'b1, 6'd5, 16'hFFFF, RUN_START);
		send_word(FUNC_UNUSED_LAST, 1'b0, 1'b0, 1'b1, 1'b1, 6'd7, 16'hFFFF, RUN_RESET);
		send_word(FUNC_RUN, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_RESET);
		send_word(FUNC_RUN, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_STOP);

		for (int ph = 0; ph < 8; ph++) begin
			send_idle_pct = (ph < 3) ? 18 : (ph < 6) ? 56 : 0;
			recv_idle_pct = (ph < 3) ? 56 : (ph < 6) ? 18 : 0;
			first = 5'($urandom_range(31));
			last = 5'($urandom_range(31));
			case (ph)
				0: begin
					mode_w = MODE_NORMAL;
					first = '0;
					last = 5'd31;
				end
				1: begin
					mode_w = MODE_PENDULUM;
					first = 5'd31;
					last = '0;
				end
				2: begin
					mode_w = MODE_RANDOM;
					first = '0;
					last = 5'd31;
				end
				3: begin
					// empty range: random order stays on one step
					mode_w = MODE_RANDOM;
					last = first;
				end
				4: mode_w = MODE_UNUSED;
				5: mode_w = MODE_PENDULUM;
				6: mode_w = MODE_RANDOM;
				default: mode_w = MODE_NORMAL;
			endcase
			apply_settings(mode_w, first, last, ph == 0);
			send_word(FUNC_RUN, pin_level, 1'b1, 1'b0, 1'b0, 6'd0, 16'h0000, RUN_START);
			repeat (75)
				send_random_word();
		end

		in_valid <= 1'b0;
		while (pending_words != 0)
			@(negedge clk);
		repeat (40)
			@(negedge clk);
		if (fail_count == 0 && pending_words == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

[step_sequencer_channel.f]
rtl/core/ssc_pkg.sv
rtl/core/ssc_rem_unit.sv
rtl/core/ssc_level_mem.sv
rtl/core/step_sequencer_channel.sv
test/step_sequencer_channel_checker.sv
test/step_sequencer_channel_test.sv
